// ----- rtl/core/nphc_pkg.sv -----
// Package for the nearest-point search block: result field widths,
// operation and status codes, and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package nphc_pkg;

    // Fixed result field widths
    localparam int SQ_W     = 42;
    localparam int DIST_W   = 21;
    localparam int IDX_O_W  = 12;
    localparam int SUM_W    = 54;
    localparam int QCNT_W   = 13;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 3;

    // Operation codes (s_axis_tuser)
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [SQ_W-1:0]   SQ_MAX   = '1;
    localparam logic [QCNT_W-1:0] QCNT_MAX = '1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SQRT  = 6'b000100,
        S_ACCUM = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage

// ----- rtl/core/nearest_point_hausdorff_chamfer.sv -----
// Top level of the nearest-point search with Hausdorff and Chamfer summary.
// Depends on nphc_pkg; holds the reference point memory and all datapaths.
`timescale 1ns / 1ps
//
// Usage:
//  Input stream (s_axis_*): tuser selects the operation (load reference
//  point, query point, clear store and accumulators), tdata carries x, y, z,
//  tlast marks the last query of a cloud. Each transaction yields exactly one
//  result transaction on m_axis_*.
//  Load, clear, unused codes and non-last queries on an empty store go from
//  acceptance through the S_OUT state into the output register. A query on
//  a non-empty store passes the memory scan (one stored point read per cycle
//  from the single read port, then a three-stage distance pipeline to
//  drain), the square root (one result bit per cycle plus a finishing step)
//  and the accumulate state; a last query then adds, or on an empty store
//  goes straight to, the Chamfer division (one quotient bit per cycle).
//  One transaction is in work at a time.
//  The result sits in an output register; the next input transaction is
//  taken while it waits. If the receiver stalls, a finished result holds
//  the block until the output register frees.
//  Reset (aresetn low, synchronous) empties the store and clears the
//  accumulators and the output valid; memory contents are not cleared.
module nearest_point_hausdorff_chamfer
    import nphc_pkg::*;
#(
    parameter int REF_DEPTH  = 4096,
    parameter int COORD_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // coord_x, coord_y, coord_z, zero pad
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic [1:0]            s_axis_tuser,
    // last_query
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // nearest_sq, nearest_distance, nearest_index, hausdorff_distance,
    // chamfer_mean, zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // status, summary_valid
    output logic [M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int CB     = COORD_BITS;
    localparam int IDX_W  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int RC_W   = $clog2(REF_DEPTH + 1);
    localparam int PT_W   = 3 * CB;
    localparam int DIFF_W = CB + 2;
    localparam int MAG_W  = CB + 1;
    localparam int SQL_W  = 2 * MAG_W;
    localparam int SUM3_W = SQL_W + 2;
    localparam int BW     = (SUM3_W > SQ_W) ? SUM3_W : SQ_W;
    localparam logic [RC_W-1:0] DEPTH_C = RC_W'(REF_DEPTH);

    // Reference point memory, one packed x/y/z word per entry
    logic [PT_W-1:0] mem [REF_DEPTH];
    logic [PT_W-1:0] rd_data_reg;

    state_t state_reg, state_next;

    logic [RC_W-1:0]   ref_count_reg, ref_count_next;
    logic [DIST_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;

    logic [PT_W-1:0] qpt_reg, qpt_next;
    logic            last_reg, last_next;

    // Scan issue counter and pipeline
    logic [RC_W-1:0]  issue_reg, issue_next;
    logic             p1_v_reg, p2_v_reg, p3_v_reg;
    logic [IDX_W-1:0] p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [MAG_W-1:0] p2_mx_reg, p2_my_reg, p2_mz_reg;
    logic [SQL_W-1:0] p3_sx_reg, p3_sy_reg, p3_sz_reg;
    logic [SUM3_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    // Square root unit
    logic [SQ_W-1:0] sq_v_reg, sq_v_next, sq_r_reg, sq_r_next, sq_b_reg, sq_b_next;

    // Divider
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [QCNT_W-1:0] rem_reg, rem_next;
    logic [5:0]        dcnt_reg, dcnt_next;

    // Result holding registers
    logic [1:0]         res_st_reg, res_st_next;
    logic [SQ_W-1:0]    res_sq_reg, res_sq_next;
    logic [DIST_W-1:0]  res_d_reg, res_d_next;
    logic [IDX_O_W-1:0] res_idx_reg, res_idx_next;
    logic               res_sv_reg, res_sv_next;
    logic [DIST_W-1:0]  res_h_reg, res_h_next;
    logic [SQ_W-1:0]    res_c_reg, res_c_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;

    logic accept;
    logic mem_we;
    logic issue_en;
    logic [MAG_W-1:0] mag_x, mag_y, mag_z;
    logic [SUM3_W-1:0] dist3;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_we        = accept && (s_axis_tuser == OP_LOAD) && (ref_count_reg != DEPTH_C);
    assign issue_en      = (state_reg == S_SCAN) && (issue_reg != ref_count_reg);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Memory write on load, registered read during scan
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ref_count_reg[IDX_W-1:0]] <= s_axis_tdata[PT_W-1:0];
        end
        rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
    end

    // Absolute coordinate differences of the point just read
    always_comb begin
        logic signed [DIFF_W-1:0] dx, dy, dz;
        dx = $signed({{2{rd_data_reg[CB-1]}}, rd_data_reg[CB-1:0]})
           - $signed({{2{qpt_reg[CB-1]}}, qpt_reg[CB-1:0]});
        dy = $signed({{2{rd_data_reg[2*CB-1]}}, rd_data_reg[2*CB-1:CB]})
           - $signed({{2{qpt_reg[2*CB-1]}}, qpt_reg[2*CB-1:CB]});
        dz = $signed({{2{rd_data_reg[3*CB-1]}}, rd_data_reg[3*CB-1:2*CB]})
           - $signed({{2{qpt_reg[3*CB-1]}}, qpt_reg[3*CB-1:2*CB]});
        mag_x = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        mag_y = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        mag_z = dz[DIFF_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
    end

    assign dist3 = SUM3_W'(p3_sx_reg) + SUM3_W'(p3_sy_reg) + SUM3_W'(p3_sz_reg);

    // Distance pipeline: read, difference, square
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= issue_en;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
        p1_idx_reg <= issue_reg[IDX_W-1:0];
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        p2_mx_reg  <= mag_x;
        p2_my_reg  <= mag_y;
        p2_mz_reg  <= mag_z;
        p3_sx_reg  <= p2_mx_reg * p2_mx_reg;
        p3_sy_reg  <= p2_my_reg * p2_my_reg;
        p3_sz_reg  <= p2_mz_reg * p2_mz_reg;
    end

    // Sequencer and datapath next values
    always_comb begin
        logic [BW-1:0]      best_w;
        logic [SQ_W-1:0]    trial;
        logic [SUM_W:0]     sum_t;
        logic [QCNT_W:0]    rem_sh;
        logic [QCNT_W-1:0]  qcnt_a;
        logic [SUM_W-1:0]   sum_a;

        state_next     = state_reg;
        ref_count_next = ref_count_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        qcnt_next      = qcnt_reg;
        qpt_next       = qpt_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        sq_v_next      = sq_v_reg;
        sq_r_next      = sq_r_reg;
        sq_b_next      = sq_b_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        res_st_next    = res_st_reg;
        res_sq_next    = res_sq_reg;
        res_d_next     = res_d_reg;
        res_idx_next   = res_idx_reg;
        res_sv_next    = res_sv_reg;
        res_h_next     = res_h_reg;
        res_c_next     = res_c_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        best_w = '0;
        trial  = '0;
        sum_t  = '0;
        rem_sh = '0;
        qcnt_a = '0;
        sum_a  = '0;

        // Release the output register
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    qpt_next     = s_axis_tdata[PT_W-1:0];
                    last_next    = s_axis_tlast;
                    res_st_next  = ST_OK;
                    res_sq_next  = '0;
                    res_d_next   = '0;
                    res_idx_next = '0;
                    res_sv_next  = 1'b0;
                    res_h_next   = '0;
                    res_c_next   = '0;
                    state_next   = S_OUT;
                    case (s_axis_tuser)
                        OP_LOAD: begin
                            if (ref_count_reg == DEPTH_C) begin
                                res_st_next = ST_FULL;
                            end else begin
                                ref_count_next = ref_count_reg + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (ref_count_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                if (s_axis_tlast) begin
                                    dvd_next   = sum_reg;
                                    rem_next   = '0;
                                    dcnt_next  = 6'(SUM_W);
                                    state_next = S_DIV;
                                end
                            end else begin
                                issue_next = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            ref_count_next = '0;
                            max_next       = '0;
                            sum_next       = '0;
                            qcnt_next      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue_en) begin
                    issue_next = issue_reg + 1'b1;
                end
                // Keep the lowest index on ties
                if (p3_v_reg && ((p3_idx_reg == '0) || (dist3 < best_reg))) begin
                    best_next     = dist3;
                    best_idx_next = p3_idx_reg;
                end
                if (!issue_en && !p1_v_reg && !p2_v_reg && !p3_v_reg) begin
                    best_w       = BW'(best_reg);
                    res_sq_next  = (best_w > BW'(SQ_MAX)) ? SQ_MAX : best_w[SQ_W-1:0];
                    res_idx_next = IDX_O_W'(best_idx_reg);
                    sq_v_next    = res_sq_next;
                    sq_r_next    = '0;
                    sq_b_next    = SQ_W'(1) << (SQ_W - 2);
                    state_next   = S_SQRT;
                end
            end
            S_SQRT: begin
                // One root bit per cycle
                if (sq_b_reg == '0) begin
                    res_d_next = DIST_W'(sq_r_reg);
                    state_next = S_ACCUM;
                end else begin
                    trial = sq_r_reg + sq_b_reg;
                    if (sq_v_reg >= trial) begin
                        sq_v_next = sq_v_reg - trial;
                        sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
                    end else begin
                        sq_r_next = sq_r_reg >> 1;
                    end
                    sq_b_next = sq_b_reg >> 2;
                end
            end
            S_ACCUM: begin
                if (res_d_reg > max_reg) begin
                    max_next = res_d_reg;
                end
                sum_t  = {1'b0, sum_reg} + (SUM_W+1)'(res_sq_reg);
                sum_a  = sum_t[SUM_W] ? '1 : sum_t[SUM_W-1:0];
                qcnt_a = (qcnt_reg != QCNT_MAX) ? qcnt_reg + 1'b1 : qcnt_reg;
                sum_next  = sum_a;
                qcnt_next = qcnt_a;
                if (last_reg) begin
                    dvd_next   = sum_a;
                    rem_next   = '0;
                    dcnt_next  = 6'(SUM_W);
                    state_next = S_DIV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle
                if (dcnt_reg == '0) begin
                    res_sv_next = 1'b1;
                    res_h_next  = max_reg;
                    if (qcnt_reg == '0) begin
                        res_c_next = '0;
                    end else if (dvd_reg[SUM_W-1:SQ_W] != '0) begin
                        res_c_next = SQ_MAX;
                    end else begin
                        res_c_next = dvd_reg[SQ_W-1:0];
                    end
                    max_next   = '0;
                    sum_next   = '0;
                    qcnt_next  = '0;
                    state_next = S_OUT;
                end else begin
                    rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
                    if (rem_sh >= {1'b0, qcnt_reg}) begin
                        rem_next = QCNT_W'(rem_sh - {1'b0, qcnt_reg});
                        dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_next = rem_sh[QCNT_W-1:0];
                        dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, res_c_reg, res_h_reg, res_idx_reg,
                                    res_d_reg, res_sq_reg};
                    m_user_next  = {res_sv_reg, res_st_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ref_count_reg <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            qcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ref_count_reg <= ref_count_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            qcnt_reg      <= qcnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        qpt_reg      <= qpt_next;
        last_reg     <= last_next;
        issue_reg    <= issue_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        sq_v_reg     <= sq_v_next;
        sq_r_reg     <= sq_r_next;
        sq_b_reg     <= sq_b_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        res_st_reg   <= res_st_next;
        res_sq_reg   <= res_sq_next;
        res_d_reg    <= res_d_next;
        res_idx_reg  <= res_idx_next;
        res_sv_reg   <= res_sv_next;
        res_h_reg    <= res_h_next;
        res_c_reg    <= res_c_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

endmodule

// ----- rtl/core/nphc_checker.sv -----
// Port-level checker for the nearest-point search block, bound to the top
// level. Depends on nphc_pkg.
`timescale 1ns / 1ps

module nphc_checker
    import nphc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Summary fields are zero without a summary
    a_no_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[2] |->
            m_axis_tdata[95:75] == '0 && m_axis_tdata[137:96] == '0)
        else $error("summary fields set without summary");

    // Flagged results carry no nearest point
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser[1:0] == ST_EMPTY || m_axis_tuser[1:0] == ST_FULL)
            |-> m_axis_tdata[74:0] == '0)
        else $error("nearest fields set on flagged result");

    // Unused status code never appears
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("invalid status code");

endmodule

bind nearest_point_hausdorff_chamfer nphc_checker u_nphc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/nearest_point_hausdorff_chamfer_tb.sv -----
// Self-checking testbench for nearest_point_hausdorff_chamfer: loads, queries,
// clears and summaries against an in-bench nearest-point predictor. Needs nphc_pkg.
`timescale 1ns / 1ps

module nearest_point_hausdorff_chamfer_tb;
    import nphc_pkg::*;

    localparam int DEPTH      = 4096;
    localparam int CB         = 20;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_CAP  = 1000000;
    localparam int QUIET_TAIL = 30;

    typedef struct {
        logic [1:0]          op;
        logic signed [CB-1:0] x, y, z;
        logic                last;
    } point_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SQ_W-1:0]   sq;
        logic [DIST_W-1:0] root;
        logic [11:0]       idx;
        logic              sv;
        logic [DIST_W-1:0] haus;
        logic [SQ_W-1:0]   cham;
    } search_res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic s_axis_tlast = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    nearest_point_hausdorff_chamfer dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Predictor state: reference cloud and running accumulators
    logic signed [CB-1:0] cloud_x [DEPTH];
    logic signed [CB-1:0] cloud_y [DEPTH];
    logic signed [CB-1:0] cloud_z [DEPTH];
    int unsigned          cloud_size;
    longint unsigned      worst_dist, sq_total, n_queries;

    point_cmd_t  pending_cmds[$];
    search_res_t expected_results[$];
    int          n_errors, n_checked, n_summaries, n_found;
    bit          stim_done, quiet;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned axis_sq(logic signed [CB-1:0] a,
                                                logic signed [CB-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d * d);
    endfunction

    // Compute the result of one command and update predictor state
    function automatic search_res_t nearest_search(point_cmd_t c);
        search_res_t     r;
        longint unsigned s, best;
        r = '0;
        best = 0;
        case (c.op)
            OP_LOAD: begin
                if (cloud_size >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    cloud_x[cloud_size] = c.x;
                    cloud_y[cloud_size] = c.y;
                    cloud_z[cloud_size] = c.z;
                    cloud_size++;
                end
            end
            OP_QUERY: begin
                if (cloud_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < cloud_size; i++) begin
                        s = axis_sq(cloud_x[i], c.x) + axis_sq(cloud_y[i], c.y)
                          + axis_sq(cloud_z[i], c.z);
                        if (i == 0 || s < best) begin
                            best = s;
                            r.idx = 12'(i);
                        end
                    end
                    if (best > SQ_MAX) best = SQ_MAX;
                    r.sq = SQ_W'(best);
                    r.root = DIST_W'(floor_sqrt(best));
                    if (r.root > worst_dist) worst_dist = r.root;
                    if (sq_total + best > (64'd1 << SUM_W) - 1)
                        sq_total = (64'd1 << SUM_W) - 1;
                    else
                        sq_total += best;
                    if (n_queries < QCNT_MAX) n_queries++;
                    n_found++;
                end
                if (c.last) begin
                    r.sv = 1;
                    r.haus = DIST_W'(worst_dist);
                    if (n_queries != 0) begin
                        s = sq_total / n_queries;
                        r.cham = (s > SQ_MAX) ? SQ_MAX : SQ_W'(s);
                    end
                    worst_dist = 0;
                    sq_total = 0;
                    n_queries = 0;
                    n_summaries++;
                end
            end
            OP_CLEAR: begin
                cloud_size = 0;
                worst_dist = 0;
                sq_total = 0;
                n_queries = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: present queued commands, with random idle bursts
    int src_gap;
    always @(posedge aclk) begin
        point_cmd_t c;
        logic nv;
        nv = s_axis_tvalid;
        if (!aresetn) begin
            nv = 0;
            src_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                c.op = s_axis_tuser;
                c.x = s_axis_tdata[19:0];
                c.y = s_axis_tdata[39:20];
                c.z = s_axis_tdata[59:40];
                c.last = s_axis_tlast;
                expected_results = {expected_results, nearest_search(c)};
            end
            nv = 0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                nv = 1;
                s_axis_tuser <= c.op;
                s_axis_tdata <= {4'b0, c.z, c.y, c.x};
                s_axis_tlast <= c.last;
                if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7);
            end else if (stim_done) begin
                stim_done = stim_done;
            end
        end
        s_axis_tvalid <= nv;
    end

    // Receiver backpressure in random bursts
    int sink_stall;
    always @(posedge aclk) begin
        if (!aresetn) begin
            sink_stall = 0;
            m_axis_tready <= 0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            sink_stall = $urandom_range(0, 6);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        search_res_t e, a;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            a.sq     = m_axis_tdata[41:0];
            a.root   = m_axis_tdata[62:42];
            a.idx    = m_axis_tdata[74:63];
            a.haus   = m_axis_tdata[95:75];
            a.cham   = m_axis_tdata[137:96];
            a.status = m_axis_tuser[1:0];
            a.sv     = m_axis_tuser[2];
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: unexpected result transaction");
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (a !== e) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: result %0d exp st=%0d sq=%0d d=%0d i=%0d sv=%0d h=%0d c=%0d",
                                 n_checked, e.status, e.sq, e.root, e.idx, e.sv, e.haus, e.cham);
                        $display("       got st=%0d sq=%0d d=%0d i=%0d sv=%0d h=%0d c=%0d",
                                 a.status, a.sq, a.root, a.idx, a.sv, a.haus, a.cham);
                    end
                end
            end
        end
    end

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return CB'($urandom);
            1: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
            default: return CB'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    task automatic queue_cmd(logic [1:0] op, logic signed [CB-1:0] x,
                             logic signed [CB-1:0] y, logic signed [CB-1:0] z,
                             logic last);
        point_cmd_t c;
        c.op = op;
        c.x = x;
        c.y = y;
        c.z = z;
        c.last = last;
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic queue_rand(logic [1:0] op, logic last);
        queue_cmd(op, rand_coord(), rand_coord(), rand_coord(), last);
    endtask

    initial begin
        int n_rand, cycles, k;
        n_errors = 0;
        n_checked = 0;
        n_summaries = 0;
        n_found = 0;
        cloud_size = 0;
        worst_dist = 0;
        sq_total = 0;
        n_queries = 0;
        stim_done = 0;
        quiet = 0;

        // Directed: empty store, unused code, extremes, ties, ignored tlast
        queue_cmd(OP_QUERY, 0, 0, 0, 0);
        queue_cmd(OP_QUERY, 5, -5, 7, 1);
        queue_cmd(OP_UNUSED, -1, -1, -1, 1);
        queue_cmd(OP_LOAD, 20'sh80000, 20'sh80000, 20'sh80000, 1);
        queue_cmd(OP_QUERY, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0);
        queue_cmd(OP_LOAD, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0);
        queue_cmd(OP_LOAD, 100, 200, -300, 0);
        queue_cmd(OP_LOAD, 100, 200, -300, 0);
        queue_cmd(OP_QUERY, 100, 200, -300, 0);
        queue_cmd(OP_QUERY, 101, 199, -301, 0);
        queue_cmd(OP_QUERY, 20'sh7FFFF, 20'sh80000, 0, 1);
        queue_cmd(OP_QUERY, 0, 0, 0, 1);
        queue_cmd(OP_CLEAR, 1, 2, 3, 1);
        queue_cmd(OP_QUERY, 1, 2, 3, 1);

        // Random: mostly small clouds followed by query runs ending in a summary
        n_rand = 0;
        while (n_rand < 118) begin
            if ($urandom_range(0, 2) == 0) begin
                queue_rand(OP_CLEAR, $urandom_range(0, 1));
                n_rand++;
            end
            k = $urandom_range(1, 12);
            for (int i = 0; i < k; i++) queue_rand(OP_LOAD, $urandom_range(0, 7) == 0);
            n_rand += k;
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) queue_rand(OP_QUERY, i == k - 1);
            n_rand += k;
            case ($urandom_range(0, 5))
                0: queue_rand(OP_UNUSED, $urandom_range(0, 1));
                1: queue_rand(OP_QUERY, $urandom_range(0, 1));
                default: ;
            endcase
        end
        stim_done = 1;

        // Reset, then run until everything is sent and answered
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        cycles = 0;
        while ((pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
               && cycles < CYCLE_CAP) begin
            @(posedge aclk);
            cycles++;
            if (pending_cmds.size() < QUIET_TAIL) quiet = 1;
        end
        if (cycles >= CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            repeat (100) @(posedge aclk);
            $display("Checked %0d results: %0d nearest-point searches, %0d summaries,",
                     n_checked, n_found, n_summaries);
            $display("with clears, unused codes, extreme coordinates and empty-store queries.");
            if (n_errors == 0 && expected_results.size() == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("Mismatches: %0d", n_errors);
                $display("[FAIL] regression broken");
            end
            $finish;
        end
    end

endmodule
